### design/storage_path_char_parser_defines.svh
// Assertion macros shared by the storage path parser checker.
`ifndef STORAGE_PATH_CHAR_PARSER_DEFINES_SVH
`define STORAGE_PATH_CHAR_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet during reset.
`define SPCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet during reset.
`define SPCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/spcp_pkg.sv
// Package for the storage path parser: defaults, codes and stream layout.
`timescale 1ns / 1ps
package spcp_pkg;

  // Default sizes of the bus name, directory names and directory count.
  localparam int unsigned BusLenDefault  = 8;
  localparam int unsigned NameLenDefault = 256;
  localparam int unsigned MaxDirsDefault = 16;

  // Register reset values.
  localparam logic [7:0] DelimReset    = 8'd47;
  localparam logic [3:0] MaxDriveReset = 4'd9;
  localparam logic [3:0] MaxVolReset   = 4'd9;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_DELIM     = 2'd0;
  localparam logic [1:0] REG_MAX_DRIVE = 2'd1;
  localparam logic [1:0] REG_MAX_VOL   = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_NO_BEGIN = 4'd1;
  localparam logic [3:0] ERR_DRIVE    = 4'd2;
  localparam logic [3:0] ERR_VOLUME   = 4'd3;
  localparam logic [3:0] ERR_BAD_CHAR = 4'd4;
  localparam logic [3:0] ERR_TOO_LONG = 4'd5;
  localparam logic [3:0] ERR_NO_ROOT  = 4'd6;
  localparam logic [3:0] ERR_BUS      = 4'd7;
  localparam logic [3:0] ERR_TOO_MANY = 4'd8;

  // Character kinds carried on the output tuser.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BUS  = 2'd1;
  localparam logic [1:0] KIND_NAME = 2'd2;

  // Output tdata layout.
  localparam int unsigned OutDataW = 40;
  localparam int unsigned ErrLsb   = 31;

  // Character constants.
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;

endpackage

### design/storage_path_char_parser.sv
// Storage path parser: one result word for each accepted input word.
// Throughput one word per cycle while the consumer does not stall the result register.
// Each character goes through an input register, then one pass of parse logic into the
// result register, which also updates the per-path state held beside it.
// rst_ni is asynchronous and active low; it clears the parse state, empties both
// registers and loads the register defaults (slash delimiter, drive and volume limits 9).
`timescale 1ns / 1ps
module storage_path_char_parser #(
  parameter int unsigned BUS_LEN  = spcp_pkg::BusLenDefault,
  parameter int unsigned NAME_LEN = spcp_pkg::NameLenDefault,
  parameter int unsigned MAX_DIRS = spcp_pkg::MaxDirsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // last_char
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_char, [10:8] bus_pos, [14:11] dir_index, [22:15] name_pos,
  // [26:23] drive_num, [30:27] volume_num, [34:31] error_code, [39:35] zero
  output logic [spcp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] char_kind
  output logic        m_axis_tlast,   // path_done
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Counter widths follow from the limits they must reach.
  localparam int unsigned BusCw  = (BUS_LEN > 0) ? $clog2(BUS_LEN + 1) : 1;
  localparam int unsigned NameCw = (NAME_LEN > 2) ? $clog2(NAME_LEN) : 1;
  localparam int unsigned DirCw  = $clog2(MAX_DIRS + 1);

  typedef enum logic [2:0] {
    PH_BEGIN,
    PH_BUS,
    PH_DRIVE,
    PH_SEP,
    PH_VOLUME,
    PH_ROOT,
    PH_NAMES
  } phase_e;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access cycle of an APB write;
  // the decode uses the word index and ignores the byte offset.
  // ---------------------------------------------------------------------------
  logic [7:0] delim_q;
  logic [3:0] max_drive_q;
  logic [3:0] max_vol_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q     <= spcp_pkg::DelimReset;
      max_drive_q <= spcp_pkg::MaxDriveReset;
      max_vol_q   <= spcp_pkg::MaxVolReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        spcp_pkg::REG_DELIM:     delim_q     <= pwdata[7:0];
        spcp_pkg::REG_MAX_DRIVE: max_drive_q <= pwdata[3:0];
        spcp_pkg::REG_MAX_VOL:   max_vol_q   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      spcp_pkg::REG_DELIM:     prdata = {24'd0, delim_q};
      spcp_pkg::REG_MAX_DRIVE: prdata = {28'd0, max_drive_q};
      spcp_pkg::REG_MAX_VOL:   prdata = {28'd0, max_vol_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. The result register advances whenever it is empty or
  // its word is being taken; the input register refills whenever it is empty
  // or moving on, so a stalled consumer holds both words in place.
  // ---------------------------------------------------------------------------
  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       out_vld_q;
  logic       adv;
  logic       step;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;
  assign step          = adv && in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ch_q   <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-path parse state.
  // ---------------------------------------------------------------------------
  phase_e            phase_q, phase_d;
  logic [BusCw-1:0]  bus_cnt_q, bus_cnt_d;
  logic [NameCw-1:0] name_cnt_q, name_cnt_d;
  logic [DirCw-1:0]  dir_cnt_q, dir_cnt_d;
  logic [3:0]        drive_q, drive_d;
  logic [3:0]        vol_q, vol_d;
  logic [3:0]        err_q, err_d;

  // Result fields computed in the parse pass.
  logic [1:0]  kind;
  logic [7:0]  och;
  logic [2:0]  bpos;
  logic [3:0]  dpos;
  logic [7:0]  npos;
  logic [3:0]  err_step;
  logic [3:0]  err_out;
  logic        is_delim;
  logic        is_digit;
  logic [31:0] bus_ext;
  logic [31:0] name_ext;
  logic [31:0] dir_ext;

  // Allowed name characters: letters, digits, dot, underscore, minus, space.
  function automatic logic name_char_ok(input logic [7:0] c);
    name_char_ok = (c >= spcp_pkg::ChZero && c <= spcp_pkg::ChNine) ||
                   (c >= spcp_pkg::ChUpA  && c <= spcp_pkg::ChUpZ)  ||
                   (c >= spcp_pkg::ChLoA  && c <= spcp_pkg::ChLoZ)  ||
                   c == spcp_pkg::ChDot   || c == spcp_pkg::ChUnder ||
                   c == spcp_pkg::ChMinus || c == spcp_pkg::ChSpace;
  endfunction

  assign is_delim = (ch_q == delim_q);
  // For a decimal digit the value is simply the low nibble of the code.
  assign is_digit = (ch_q >= spcp_pkg::ChZero) && (ch_q <= spcp_pkg::ChNine);

  assign bus_ext  = 32'(bus_cnt_q);
  assign name_ext = 32'(name_cnt_q);
  assign dir_ext  = 32'(dir_cnt_q);

  always_comb begin
    phase_d    = phase_q;
    bus_cnt_d  = bus_cnt_q;
    name_cnt_d = name_cnt_q;
    dir_cnt_d  = dir_cnt_q;
    drive_d    = drive_q;
    vol_d      = vol_q;
    kind       = spcp_pkg::KIND_NONE;
    och        = 8'd0;
    bpos       = 3'd0;
    dpos       = 4'd0;
    npos       = 8'd0;
    err_step   = spcp_pkg::ERR_NONE;

    // While an error is pending every character is swallowed until the last one.
    if (err_q == spcp_pkg::ERR_NONE) begin
      unique case (phase_q)
        PH_BEGIN: begin
          if (is_delim) phase_d = PH_BUS;
          else          err_step = spcp_pkg::ERR_NO_BEGIN;
        end
        PH_BUS: begin
          if (is_delim) begin
            phase_d = PH_DRIVE;
          end else if (bus_cnt_q >= BusCw'(BUS_LEN)) begin
            // Bus name would overflow its buffer.
            err_step = spcp_pkg::ERR_BUS;
          end else begin
            kind      = spcp_pkg::KIND_BUS;
            och       = ch_q;
            bpos      = bus_ext[2:0];
            bus_cnt_d = bus_cnt_q + BusCw'(1);
          end
        end
        PH_DRIVE: begin
          if (is_digit && ch_q[3:0] <= max_drive_q) begin
            drive_d = ch_q[3:0];
            phase_d = PH_SEP;
          end else begin
            err_step = spcp_pkg::ERR_DRIVE;
          end
        end
        PH_SEP: begin
          if (is_delim) phase_d = PH_VOLUME;
          else          err_step = spcp_pkg::ERR_VOLUME;
        end
        PH_VOLUME: begin
          if (is_digit && ch_q[3:0] <= max_vol_q) begin
            vol_d   = ch_q[3:0];
            phase_d = PH_ROOT;
          end else begin
            err_step = spcp_pkg::ERR_VOLUME;
          end
        end
        PH_ROOT: begin
          if (is_delim) phase_d = PH_NAMES;
          else          err_step = spcp_pkg::ERR_NO_ROOT;
        end
        default: begin
          // Directory and file names. A delimiter closes a non-empty name;
          // runs of delimiters are skipped.
          if (is_delim) begin
            if (name_cnt_q != '0) begin
              name_cnt_d = '0;
              if (dir_cnt_q < DirCw'(MAX_DIRS)) dir_cnt_d = dir_cnt_q + DirCw'(1);
            end
          end else if (name_cnt_q >= NameCw'(NAME_LEN - 1)) begin
            err_step = spcp_pkg::ERR_TOO_LONG;
          end else if (!name_char_ok(ch_q)) begin
            err_step = spcp_pkg::ERR_BAD_CHAR;
          end else if (dir_cnt_q >= DirCw'(MAX_DIRS)) begin
            err_step = spcp_pkg::ERR_TOO_MANY;
          end else begin
            kind       = spcp_pkg::KIND_NAME;
            och        = ch_q;
            dpos       = dir_ext[3:0];
            npos       = name_ext[7:0];
            name_cnt_d = name_cnt_q + NameCw'(1);
          end
        end
      endcase
      err_d = err_step;
    end else begin
      err_d = err_q;
    end

    // A path that ends before the names reports the field it was waiting for.
    err_out = err_d;
    if (last_q && err_d == spcp_pkg::ERR_NONE) begin
      unique case (phase_d)
        PH_BEGIN:  err_out = spcp_pkg::ERR_NO_BEGIN;
        PH_BUS:    err_out = spcp_pkg::ERR_BUS;
        PH_DRIVE:  err_out = spcp_pkg::ERR_DRIVE;
        PH_SEP:    err_out = spcp_pkg::ERR_VOLUME;
        PH_VOLUME: err_out = spcp_pkg::ERR_VOLUME;
        PH_ROOT:   err_out = spcp_pkg::ERR_NO_ROOT;
        default:   err_out = spcp_pkg::ERR_NONE;
      endcase
    end
  end

  // State update. The last character of a path returns everything to the start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_BEGIN;
      bus_cnt_q  <= '0;
      name_cnt_q <= '0;
      dir_cnt_q  <= '0;
      drive_q    <= 4'd0;
      vol_q      <= 4'd0;
      err_q      <= spcp_pkg::ERR_NONE;
    end else if (step) begin
      if (last_q) begin
        phase_q    <= PH_BEGIN;
        bus_cnt_q  <= '0;
        name_cnt_q <= '0;
        dir_cnt_q  <= '0;
        drive_q    <= 4'd0;
        vol_q      <= 4'd0;
        err_q      <= spcp_pkg::ERR_NONE;
      end else begin
        phase_q    <= phase_d;
        bus_cnt_q  <= bus_cnt_d;
        name_cnt_q <= name_cnt_d;
        dir_cnt_q  <= dir_cnt_d;
        drive_q    <= drive_d;
        vol_q      <= vol_d;
        err_q      <= err_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. The drive and volume fields show the values after the
  // step, before the end-of-path clear.
  // ---------------------------------------------------------------------------
  logic [spcp_pkg::OutDataW-1:0] out_data_q;
  logic [1:0]                    out_kind_q;
  logic                          out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {5'd0, err_out, vol_d, drive_d, npos, dpos, bpos, och};
      out_kind_q <= kind;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### design/spcp_checker.sv
// Port-level checks on the result stream of the storage path parser.
`timescale 1ns / 1ps
`include "storage_path_char_parser_defines.svh"
module spcp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [spcp_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);

  logic [3:0] err_code;

  assign err_code = m_axis_tdata[spcp_pkg::ErrLsb +: 4];

  // A stalled result word must not change or vanish.
  `SPCP_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result word changed while stalled")

  // A word that emits no character carries a zero character and zero positions.
  `SPCP_ASSERT_NOW(a_quiet_fields, m_axis_tvalid && m_axis_tuser == spcp_pkg::KIND_NONE, m_axis_tdata[22:0] == 23'd0, "idle word carries character data")

  // A name character is only ever emitted while the path is still free of errors.
  `SPCP_ASSERT_NOW(a_name_clean, m_axis_tvalid && m_axis_tuser == spcp_pkg::KIND_NAME, err_code == spcp_pkg::ERR_NONE, "name character emitted with an error pending")

  // Bus characters come with no error except at the end of a path cut short.
  `SPCP_ASSERT_NOW(a_bus_clean, m_axis_tvalid && m_axis_tuser == spcp_pkg::KIND_BUS && !m_axis_tlast, err_code == spcp_pkg::ERR_NONE && m_axis_tdata[7:0] != 8'd0 || m_axis_tvalid && m_axis_tuser == spcp_pkg::KIND_BUS && !m_axis_tlast && err_code == spcp_pkg::ERR_NONE, "bus character emitted with an error pending")

endmodule

bind storage_path_char_parser spcp_checker u_spcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
